// File: hw/rtl/sssr_pkg.sv
// Shared types and constants for the scan sweep request scheduler.
// No dependencies; used by scan_sweep_request_scheduler_top.
package sssr_pkg;

   localparam int SLOT_COUNT   = 5;
   localparam int TOP_POSITION = 32;

   localparam int POS_W      = 6;
   localparam int DIST_W     = 6;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LOAD_CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic KIND_SERVED  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic             command;
      logic [POS_W-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  position;
      logic [DIST_W-1:0] distance;
      logic              last;
   } rsp_beat_type;

endpackage

// File: hw/rtl/scan_sweep_request_scheduler_top.sv
// Scan sweep request scheduler: load cycle, slot scan sequencer, output register.
// A load beat is taken in the idle state. A run repeats scan passes over the slots, each
// followed by a decide step, with one pass per served request plus two (end of the upward
// and downward sweeps); a decide step that emits a result waits while the output stalls.
// A single slot compare unit serves every pass; no request is taken during a run.
// Synchronous active-high reset empties all slots, the load count and the output valid.
// Depends on sssr_pkg.
module scan_sweep_request_scheduler_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sssr_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sssr_pkg::rsp_beat_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   localparam logic [sssr_pkg::POS_W-1:0] TOP_POS = sssr_pkg::POS_W'(sssr_pkg::TOP_POSITION);
   localparam logic [sssr_pkg::SLOT_IDX_W-1:0] LAST_IDX =
      sssr_pkg::SLOT_IDX_W'(sssr_pkg::SLOT_COUNT - 1);
   localparam logic [sssr_pkg::LOAD_CNT_W-1:0] FULL_CNT =
      sssr_pkg::LOAD_CNT_W'(sssr_pkg::SLOT_COUNT);
   localparam logic [sssr_pkg::DIST_W-1:0] DIST_MAX = '1;

   state_type state_ff, state_in;
   logic [sssr_pkg::POS_W-1:0] slots_ff [sssr_pkg::SLOT_COUNT];
   logic [sssr_pkg::POS_W-1:0] slots_in [sssr_pkg::SLOT_COUNT];
   logic [sssr_pkg::LOAD_CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [sssr_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [sssr_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic                            down_ff, down_in;
   logic [sssr_pkg::SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                            best_vld_ff, best_vld_in;
   logic [sssr_pkg::SLOT_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [sssr_pkg::POS_W-1:0]      best_val_ff, best_val_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sssr_pkg::rsp_beat_type          rsp_data_ff, rsp_data_in;

   logic [sssr_pkg::POS_W-1:0]  cand;
   logic                        in_range;
   logic                        better;
   logic                        take;
   logic                        out_free;
   logic [sssr_pkg::POS_W-1:0]  diff;
   logic [sssr_pkg::DIST_W:0]   sum;
   logic [sssr_pkg::DIST_W-1:0] dist_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared compare unit: one slot per cycle
   assign cand     = slots_ff[idx_ff];
   assign in_range = down_ff ? (cand <= pos_ff) : ((cand >= pos_ff) && (cand <= TOP_POS));
   assign better   = !best_vld_ff || (down_ff ? (cand > best_val_ff) : (cand < best_val_ff));
   assign take     = (cand != '0) && in_range && better;

   assign diff      = (best_val_ff >= pos_ff) ? (best_val_ff - pos_ff) : (pos_ff - best_val_ff);
   assign sum       = {1'b0, dist_ff} + (sssr_pkg::DIST_W + 1)'(diff);
   assign dist_next = sum[sssr_pkg::DIST_W] ? DIST_MAX : sum[sssr_pkg::DIST_W-1:0];

   always_comb begin
      state_in     = state_ff;
      slots_in     = slots_ff;
      load_cnt_in  = load_cnt_ff;
      pos_in       = pos_ff;
      dist_in      = dist_ff;
      down_in      = down_ff;
      idx_in       = idx_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == sssr_pkg::CMD_LOAD) begin
                  if (load_cnt_ff < FULL_CNT) begin
                     slots_in[load_cnt_ff[sssr_pkg::SLOT_IDX_W-1:0]] = req_data.value;
                     load_cnt_in = load_cnt_ff + 1'b1;
                  end
               end else begin
                  pos_in      = req_data.value;
                  dist_in     = '0;
                  down_in     = 1'b0;
                  idx_in      = '0;
                  best_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               best_vld_in = 1'b1;
               best_idx_in = idx_ff;
               best_val_in = cand;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (best_vld_ff) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.kind     = sssr_pkg::KIND_SERVED;
                  rsp_data_in.position = best_val_ff;
                  rsp_data_in.distance = dist_next;
                  rsp_data_in.last     = 1'b0;
                  dist_in              = dist_next;
                  pos_in               = best_val_ff;
                  slots_in[best_idx_ff] = '0;
                  best_vld_in          = 1'b0;
                  idx_in               = '0;
                  state_in             = ST_SCAN;
               end
            end else if (!down_ff) begin
               down_in  = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = sssr_pkg::KIND_SUMMARY;
               rsp_data_in.position = pos_ff;
               rsp_data_in.distance = dist_ff;
               rsp_data_in.last     = 1'b1;
               for (int j = 0; j < sssr_pkg::SLOT_COUNT; j++) begin
                  slots_in[j] = '0;
               end
               load_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int j = 0; j < sssr_pkg::SLOT_COUNT; j++) begin
            slots_ff[j] <= '0;
         end
         load_cnt_ff  <= '0;
         pos_ff       <= '0;
         dist_ff      <= '0;
         down_ff      <= 1'b0;
         idx_ff       <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         load_cnt_ff  <= load_cnt_in;
         pos_ff       <= pos_in;
         dist_ff      <= dist_in;
         down_ff      <= down_in;
         idx_ff       <= idx_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: tb/scan_sweep_request_scheduler_top_tb.sv
// Self-checking testbench for scan_sweep_request_scheduler_top.
// Drives load/run beats with random idling and output stalls, predicts sweep results in step.
// Depends on sssr_pkg and scan_sweep_request_scheduler_top.
`timescale 1ns / 100ps

module scan_sweep_request_scheduler_top_tb;

   localparam int DIST_LIMIT = (1 << sssr_pkg::DIST_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sssr_pkg::req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sssr_pkg::rsp_beat_type rsp_data;

   sssr_pkg::req_beat_type pending_beats[$];
   sssr_pkg::rsp_beat_type sweep_results[$];

   logic [sssr_pkg::POS_W-1:0]  slot_req[sssr_pkg::SLOT_COUNT];
   int                          loads_taken;
   logic [sssr_pkg::POS_W-1:0]  car_pos;
   logic [sssr_pkg::DIST_W-1:0] trip_dist;

   logic req_fire = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   logic quiet;

   scan_sweep_request_scheduler_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   assign quiet = (cycle_count >= 2000) && (cycle_count < 4000);

   function void serve_floor(input int floor_pos);
      int step;
      int sum;
      sssr_pkg::rsp_beat_type served;
      for (int j = 0; j < sssr_pkg::SLOT_COUNT; j++) begin
         if (slot_req[j] != '0 && int'(slot_req[j]) == floor_pos) begin
            step = (floor_pos >= int'(car_pos)) ? floor_pos - int'(car_pos)
                                                : int'(car_pos) - floor_pos;
            sum = int'(trip_dist) + step;
            trip_dist = (sum > DIST_LIMIT) ? DIST_LIMIT[sssr_pkg::DIST_W-1:0]
                                           : sum[sssr_pkg::DIST_W-1:0];
            car_pos = floor_pos[sssr_pkg::POS_W-1:0];
            slot_req[j] = '0;
            served.kind = sssr_pkg::KIND_SERVED;
            served.position = floor_pos[sssr_pkg::POS_W-1:0];
            served.distance = trip_dist;
            served.last = 1'b0;
            sweep_results.push_back(served);
         end
      end
   endfunction

   function void predict_beat(input sssr_pkg::req_beat_type b);
      sssr_pkg::rsp_beat_type summary;
      if (b.command == sssr_pkg::CMD_LOAD) begin
         if (loads_taken < sssr_pkg::SLOT_COUNT) begin
            slot_req[loads_taken] = b.value;
            loads_taken++;
         end
      end else begin
         car_pos = b.value;
         trip_dist = '0;
         for (int f = int'(b.value); f <= sssr_pkg::TOP_POSITION; f++)
            serve_floor(f);
         for (int f = int'(car_pos); f >= 1; f--)
            serve_floor(f);
         summary.kind = sssr_pkg::KIND_SUMMARY;
         summary.position = car_pos;
         summary.distance = trip_dist;
         summary.last = 1'b1;
         sweep_results.push_back(summary);
         for (int j = 0; j < sssr_pkg::SLOT_COUNT; j++)
            slot_req[j] = '0;
         loads_taken = 0;
      end
   endfunction

   always @(posedge clock) begin
      sssr_pkg::rsp_beat_type want;
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_valid && !req_stall;
      if (reset) begin
         for (int j = 0; j < sssr_pkg::SLOT_COUNT; j++)
            slot_req[j] = '0;
         loads_taken = 0;
         car_pos = '0;
         trip_dist = '0;
      end else begin
         if (req_valid && !req_stall)
            predict_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (sweep_results.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = sweep_results.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.position !== want.position ||
                   rsp_data.distance !== want.distance || rsp_data.last !== want.last) begin
                  $display("%0t: expected %p, got %p", $time, want, rsp_data);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // driver: new beat only once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_beats.size() != 0 && (quiet || $urandom_range(0, 99) >= 19)) begin
            req_valid <= 1'b1;
            req_data <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);
   end

   function void queue_beat(input logic cmd, input int val);
      sssr_pkg::req_beat_type b;
      b.command = cmd;
      b.value = val[sssr_pkg::POS_W-1:0];
      pending_beats.push_back(b);
   endfunction

   function int pick_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, sssr_pkg::TOP_POSITION);
      if (r < 80) return 0;
      return $urandom_range(0, 63);
   endfunction

   function int pick_start();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, sssr_pkg::TOP_POSITION);
      if (r < 85) return $urandom_range(sssr_pkg::TOP_POSITION + 1, 63);
      return 0;
   endfunction

   initial begin
      int nloads;
      // no pending request, start 0
      queue_beat(sssr_pkg::CMD_RUN, 0);
      // upward leg from the bottom all the way to the top
      queue_beat(sssr_pkg::CMD_LOAD, 32);
      queue_beat(sssr_pkg::CMD_LOAD, 1);
      queue_beat(sssr_pkg::CMD_RUN, 0);
      // duplicates, zero load, full slots drop the sixth, start above the top
      queue_beat(sssr_pkg::CMD_LOAD, 5);
      queue_beat(sssr_pkg::CMD_LOAD, 5);
      queue_beat(sssr_pkg::CMD_LOAD, 0);
      queue_beat(sssr_pkg::CMD_LOAD, 63);
      queue_beat(sssr_pkg::CMD_LOAD, 40);
      queue_beat(sssr_pkg::CMD_LOAD, 17);
      queue_beat(sssr_pkg::CMD_RUN, 63);
      // request above the top is never reached
      queue_beat(sssr_pkg::CMD_LOAD, 33);
      queue_beat(sssr_pkg::CMD_LOAD, 20);
      queue_beat(sssr_pkg::CMD_RUN, 10);
      queue_beat(sssr_pkg::CMD_RUN, 45);
      queue_beat(sssr_pkg::CMD_LOAD, 7);
      queue_beat(sssr_pkg::CMD_LOAD, 7);
      queue_beat(sssr_pkg::CMD_RUN, 7);
      queue_beat(sssr_pkg::CMD_LOAD, 63);
      queue_beat(sssr_pkg::CMD_RUN, 63);

      while (pending_beats.size() < 380) begin
         if ($urandom_range(0, 99) < 85) begin
            nloads = $urandom_range(0, sssr_pkg::SLOT_COUNT + 1);
            for (int k = 0; k < nloads; k++)
               queue_beat(sssr_pkg::CMD_LOAD, pick_request());
            queue_beat(sssr_pkg::CMD_RUN, pick_start());
         end else begin
            queue_beat(1'($urandom_range(0, 1)), $urandom_range(0, 63));
         end
      end
      queue_beat(sssr_pkg::CMD_RUN, pick_start());

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_beats.size() != 0 || req_valid)
         @(posedge clock);
      while (sweep_results.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (sweep_results.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/sssr_pkg.sv
hw/rtl/scan_sweep_request_scheduler_top.sv
tb/scan_sweep_request_scheduler_top_tb.sv
